FILE: hdl/ert_pkg.sv
// ----------------------------------------------------------------------------
// Extended-range timer package
// Shared types and constants for the timer datapath and its top level.
// ----------------------------------------------------------------------------
package ert_pkg;

	// Width of the overflow accumulator and of the extended-count sums.
	localparam int EXT_WIDTH = 32;

	localparam int CNT_WIDTH   = 16;
	localparam int NARROW_BITS = 8;
	localparam int WIDE_BITS   = 16;

	localparam logic [EXT_WIDTH-1:0] PERIOD_NARROW = EXT_WIDTH'(64'd1 << NARROW_BITS);
	localparam logic [EXT_WIDTH-1:0] PERIOD_WIDE   = EXT_WIDTH'(64'd1 << WIDE_BITS);

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_SERVICE  = 3'd1,
		OP_READ     = 3'd2,
		OP_WRITE    = 3'd3,
		OP_EXT_FUT  = 3'd4,
		OP_EXT_PAST = 3'd5,
		OP_OVF_CNT  = 3'd6,
		OP_CLR_CNT  = 3'd7
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        overflow_pending;
	} out_item_t;

endpackage

FILE: hdl/ert_core.sv
// ----------------------------------------------------------------------------
// Extended-range timer core
// Holds the counter, accumulator and wrap flag, and computes one result per
// transfer from the staged item and the current state.
// ----------------------------------------------------------------------------
module ert_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             wide,
	input  ert_pkg::in_item_t  item,
	output ert_pkg::out_item_t result
);
	import ert_pkg::*;

	logic [CNT_WIDTH-1:0] hw_count_q;
	logic [EXT_WIDTH-1:0] accum_q;
	logic                 wrap_q;

	logic [CNT_WIDTH-1:0] cnt;
	logic [CNT_WIDTH-1:0] t_val;
	logic [CNT_WIDTH-1:0] cnt_inc;
	logic [EXT_WIDTH-1:0] per;
	logic [EXT_WIDTH-1:0] pend_adj;
	logic [EXT_WIDTH-1:0] val_ext;
	logic [EXT_WIDTH-1:0] comp_accum;
	logic [EXT_WIDTH-1:0] res_ext;
	logic [CNT_WIDTH-1:0] hw_count_d;
	logic [EXT_WIDTH-1:0] accum_d;
	logic                 wrap_d;
	logic                 cnt_low_half;

	always_comb begin
		per      = wide ? PERIOD_WIDE : PERIOD_NARROW;
		cnt      = wide ? hw_count_q : {{(CNT_WIDTH-NARROW_BITS){1'b0}},
			hw_count_q[NARROW_BITS-1:0]};
		t_val    = wide ? item.value[CNT_WIDTH-1:0] : {{(CNT_WIDTH-NARROW_BITS){1'b0}},
			item.value[NARROW_BITS-1:0]};
		cnt_inc  = wide ? cnt + 1'b1 : {{(CNT_WIDTH-NARROW_BITS){1'b0}},
			cnt[NARROW_BITS-1:0] + 1'b1};
		// The count sits in the lower half of the range when its top bit is clear.
		cnt_low_half = wide ? !cnt[WIDE_BITS-1] : !cnt[NARROW_BITS-1];
		pend_adj   = wrap_q ? per : '0;
		comp_accum = accum_q + pend_adj;
		val_ext    = EXT_WIDTH'(item.value);

		hw_count_d = hw_count_q;
		accum_d    = accum_q;
		wrap_d     = wrap_q;
		res_ext    = '0;

		unique case (item.op)
			OP_TICK: begin
				hw_count_d = cnt_inc;
				if (cnt_inc == '0) begin
					wrap_d = 1'b1;
				end
			end
			OP_SERVICE: begin
				accum_d = accum_q + per;
				wrap_d  = 1'b0;
			end
			OP_READ: begin
				res_ext = EXT_WIDTH'(cnt) + accum_q + ((wrap_q && cnt_low_half) ? per : '0);
			end
			OP_WRITE: begin
				hw_count_d = t_val;
				accum_d    = val_ext & ~(per - 1'b1);
				wrap_d     = 1'b0;
			end
			OP_EXT_FUT: begin
				res_ext = EXT_WIDTH'(t_val) + comp_accum + ((t_val < cnt) ? per : '0);
			end
			OP_EXT_PAST: begin
				res_ext = EXT_WIDTH'(t_val) + comp_accum - ((cnt <= t_val) ? per : '0);
			end
			OP_OVF_CNT: begin
				res_ext = wide ? (comp_accum >> WIDE_BITS) : (comp_accum >> NARROW_BITS);
			end
			OP_CLR_CNT: begin
				accum_d = '0;
			end
		endcase

		result.result_value     = 32'(res_ext);
		result.overflow_pending = wrap_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_count_q <= '0;
			accum_q    <= '0;
			wrap_q     <= 1'b0;
		end else if (advance) begin
			hw_count_q <= hw_count_d;
			accum_q    <= accum_d;
			wrap_q     <= wrap_d;
		end
	end

endmodule

FILE: hdl/extended_range_timer_top.sv
// ----------------------------------------------------------------------------
// Extended-range timer
// Widens an 8- or 16-bit tick counter to a 32-bit tick count.
// ----------------------------------------------------------------------------
// One item is taken every clock while in_stall is low. Each transfer passes an
// input register and then the result register. The state update is committed
// as an item moves into the result register, so the next item always sees the
// state left by the one before. A stalled output holds its result and the input
// register, and the input stalls only while both are full. The user must write
// the counter width register only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module extended_range_timer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  ert_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ert_pkg::out_item_t out_data
);
	import ert_pkg::*;

	logic      wide_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	out_item_t core_result;
	logic      out_free;
	logic      advance;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	ert_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.wide   (wide_q),
		.item   (item_s1),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b1;
		end else if (cfg_we) begin
			wide_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_item_q <= core_result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

endmodule
